// ===== rtl/rgi_pkg.sv =====
// Package for the readability grade index block: widths, character codes,
// index coefficients, shared types and the saturating counter step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgi_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int RAW_W   = 22;
  localparam int GRADE_W = 5;

  // Counters and derived operand widths
  localparam int CNT_W   = 17;             // letters, whitespace, sentence ends
  localparam int WORDS_W = CNT_W + 1;      // whitespace + 1
  localparam int PL_W    = 27;             // 588 * letters
  localparam int PS_W    = 30;             // 2960 * sentences + 1580 * words
  localparam int DEN_W   = 24;             // 100 * words
  localparam int DIFF_W  = 31;             // signed numerator
  localparam int MAG_W   = 30;             // numerator magnitude
  localparam int DVD_W   = 31;             // 2*|num| + den
  localparam int DVS_W   = DEN_W + 1;      // 2*den

  // Coleman-Liau coefficients, scaled by 100 per word
  localparam int K_LET  = 588;
  localparam int K_SENT = 2960;
  localparam int K_WORD = 1580;
  localparam int K_DEN  = 100;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_QM   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_EXCL = 8'h21;

  // Result limits, compared against the quotient magnitude
  localparam logic [DVD_W-1:0] RAW_POS_LIM = DVD_W'(2097151);
  localparam logic [DVD_W-1:0] RAW_NEG_LIM = DVD_W'(2097152);
  localparam logic [RAW_W-1:0] RAW_MAX     = {1'b0, {(RAW_W-1){1'b1}}};
  localparam logic [RAW_W-1:0] RAW_MIN     = {1'b1, {(RAW_W-1){1'b0}}};
  localparam logic [GRADE_W-1:0] GRADE_TOP = GRADE_W'(16);
  localparam logic [DVD_W-1:0]   GRADE_LIM = DVD_W'(16);

  typedef struct packed {
    logic [CNT_W-1:0] letters;
    logic [CNT_W-1:0] spaces;
    logic [CNT_W-1:0] sentences;
  } rgi_cnt_t;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_PROD,
    ST_DIFF,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } rgi_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgi_if.sv =====
// Valid/ready channel interfaces for text bytes in and index words out.
// Depends on rgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rgi_in_if import rgi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rgi_out_if import rgi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [RAW_W-1:0]   raw_index;
  logic        [GRADE_W-1:0] grade;

  modport source (output valid, output raw_index, output grade, input ready);
  modport sink   (input valid, input raw_index, input grade, output ready);
endinterface

`default_nettype wire

// ===== rtl/readability_grade_index.sv =====
// Coleman-Liau readability index over a byte stream.
// Input: ordinary bytes are taken one per cycle while ready is high. After the byte
//   marked last is accepted, the index is formed in the product, difference, load and
//   divide states; ready stays low until the result word is loaded into the output.
// The load waits while the output holds an earlier word that has not been taken.
// Reset: asynchronous, active low; clears counters, sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module readability_grade_index import rgi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rgi_in_if.sink     in_i,
  rgi_out_if.source  out_o
);

  rgi_state_e state_q, state_d;

  logic     in_acc;
  rgi_cnt_t counts, cap_q;

  // Operand registers for the index
  logic        [PL_W-1:0]   pl_q;
  logic        [PS_W-1:0]   ps_q;
  logic        [DEN_W-1:0]  den_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic                     neg_q;

  logic [MAG_W-1:0] mag;
  logic [DVD_W-1:0] dividend, quo;
  logic [DVS_W-1:0] divisor;
  logic             div_start, div_busy;

  // Output word register
  logic                     out_valid_q;
  logic signed [RAW_W-1:0]  raw_q, raw_d;
  logic        [GRADE_W-1:0] grade_q, grade_d;
  logic                     out_load;

  assign in_i.ready = (state_q == ST_COUNT);
  assign in_acc     = in_i.valid && in_i.ready;

  rgi_counter u_counter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .char_code_i (in_i.char_code),
    .last_char_i (in_i.last_char),
    .counts_o    (counts)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_COUNT: begin
        if (in_acc && in_i.last_char) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_LOAD;
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // output slot free or being emptied this cycle
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_COUNT;
        end
      end
      default: state_d = ST_COUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Numerator pieces 588*L and 2960*S + 1580*W, and denominator 100*W, with W = spaces + 1
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.last_char) begin
      cap_q <= counts;
    end
    if (state_q == ST_PROD) begin
      pl_q  <= PL_W'(cap_q.letters) * PL_W'(K_LET);
      ps_q  <= PS_W'(cap_q.sentences) * PS_W'(K_SENT) +
               PS_W'({1'b0, cap_q.spaces} + WORDS_W'(1)) * PS_W'(K_WORD);
      den_q <= DEN_W'({1'b0, cap_q.spaces} + WORDS_W'(1)) * DEN_W'(K_DEN);
    end
    if (state_q == ST_DIFF) begin
      diff_q <= $signed(DIFF_W'(pl_q)) - $signed(DIFF_W'(ps_q));
    end
    if (state_q == ST_LOAD) begin
      neg_q <= diff_q[DIFF_W-1];
    end
  end

  // round half away from zero: q = (2|num| + den) / (2 den)
  always_comb begin
    mag      = diff_q[DIFF_W-1] ? MAG_W'(-diff_q) : MAG_W'(diff_q);
    dividend = {mag, 1'b0} + DVD_W'(den_q);
    divisor  = {den_q, 1'b0};
  end

  rgi_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // Sign, saturate to the field, clamp the grade from the rounded index
  always_comb begin
    if (neg_q) begin
      raw_d = (quo > RAW_NEG_LIM) ? RAW_MIN : -RAW_W'(quo);
    end else begin
      raw_d = (quo > RAW_POS_LIM) ? RAW_MAX : RAW_W'(quo);
    end
    priority if (neg_q || (quo == '0)) begin
      grade_d = '0;
    end else if (quo >= GRADE_LIM) begin
      grade_d = GRADE_TOP;
    end else begin
      grade_d = GRADE_W'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      raw_q   <= raw_d;
      grade_q <= grade_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.raw_index = raw_q;
  assign out_o.grade     = grade_q;

endmodule

`default_nettype wire

// ===== rtl/rgi_counter.sv =====
// Byte classifier and the three saturating text counters.
// Depends on rgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgi_counter import rgi_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic              last_char_i,
  output rgi_cnt_t               counts_o   // totals including the current byte
);

  rgi_cnt_t cnt_q, cnt_d, upd;
  logic is_letter, is_space, is_sent;

  always_comb begin
    is_letter = ((char_code_i >= CH_UP_A) && (char_code_i <= CH_UP_Z)) ||
                ((char_code_i >= CH_LO_A) && (char_code_i <= CH_LO_Z));
    is_space  = ((char_code_i >= CH_TAB) && (char_code_i <= CH_CR)) ||
                (char_code_i == CH_SP);
    is_sent   = (char_code_i == CH_DOT) || (char_code_i == CH_QM) ||
                (char_code_i == CH_EXCL);

    upd = cnt_q;
    if (is_letter) begin
      upd.letters = sat_inc(cnt_q.letters);
    end
    if (is_space) begin
      upd.spaces = sat_inc(cnt_q.spaces);
    end
    if (is_sent) begin
      upd.sentences = sat_inc(cnt_q.sentences);
    end

    cnt_d = cnt_q;
    if (accept_i) begin
      cnt_d = last_char_i ? '0 : upd;
    end
  end

  assign counts_o = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgi_divider.sv =====
// Restoring divider, one quotient bit per cycle while busy.
// Depends on rgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgi_divider import rgi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVS_W-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W:0]    rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // no borrow: subtract and shift in a one
      if (!trial[DVS_W]) begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
